@@ rtl/ecc_pkg.sv @@
// Package for the epoch calendar converter: constants, stage records and calendar helpers.
`timescale 1ns / 1ps
`default_nettype none
package ecc_pkg;

    localparam int NStage = 9;
    localparam int InDataW = 88;
    localparam int OutDataW = 96;

    localparam logic MODE_SPLIT = 1'b0;
    localparam logic MODE_BUILD = 1'b1;

    // Offsets of 2100 and 2105 from 1970.
    localparam logic [7:0] YOFF_2100 = 8'd130;
    localparam logic [7:0] YOFF_MAX = 8'd135;

    typedef struct packed {
        logic        mode;
        logic [31:0] epoch;
        logic [7:0]  yoff;
        logic [3:0]  midx;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } st1_t;

    typedef struct packed {
        logic               mode;
        logic [31:0]        epoch;
        logic signed [17:0] days;
        logic [19:0]        tsec;
    } st2_t;

    typedef struct packed {
        logic [31:0] epoch;
    } st3_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [15:0] days;
    } st4_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [15:0] days;
        logic [16:0] tod;
        logic [7:0]  yq;
    } st5_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [15:0] days;
        logic [16:0] tod;
        logic [7:0]  yoff;
        logic [8:0]  sod;
        logic        leap;
        logic [4:0]  hour;
        logic [12:0] wq;
    } st6_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [15:0] days;
        logic [7:0]  yoff;
        logic        leap;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [11:0] remh;
    } st7_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [15:0] days;
        logic [7:0]  yoff;
        logic        leap;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [11:0] remh;
    } st8_t;

    // Days before the first of a month in a common year.
    function automatic logic [8:0] month_base(input logic [3:0] idx);
        logic [8:0] r;
        begin
            unique case (idx)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd59;
                4'd3:    r = 9'd90;
                4'd4:    r = 9'd120;
                4'd5:    r = 9'd151;
                4'd6:    r = 9'd181;
                4'd7:    r = 9'd212;
                4'd8:    r = 9'd243;
                4'd9:    r = 9'd273;
                4'd10:   r = 9'd304;
                4'd11:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Days before January 1 of 1970 + yoff, reckoned in quarter-days; exact for yoff up to 132.
    function automatic logic [15:0] days_before(input logic [7:0] yoff);
        logic [17:0] q;
        begin
            q = 18'(yoff * 11'd1461) + 18'd1;
            if (yoff > YOFF_2100)
            begin
                q = q - 18'd2;
            end
            return q[17:2];
        end
    endfunction

    function automatic logic leap_of(input logic [7:0] yoff);
        logic [7:0] t;
        begin
            t = yoff + 8'd2;
            return (t[1:0] == 2'b00) && (yoff != YOFF_2100);
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/epoch_calendar_converter_core.sv @@
// Top level of the epoch calendar converter: a nine stage conversion pipeline.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel  Direction  Handshake           Contents
//  s_*      in         s_tvalid/s_tready   one conversion request (mode on tuser)
//  m_*      out        m_tvalid/m_tready   one converted date, time and epoch
//
//  Every transfer in produces exactly one transfer out, through nine registered
//  stages. A new request is taken in every cycle while the output side does
//  not stall; the chain of constant-reciprocal multipliers is split so that
//  each is followed by a register. Each stage holds a valid bit and loads when
//  it is empty or the stage after it loads, so a stall fills the bubbles and
//  then holds everything in place. Reset clears the valid bits only.
//
//  Mode 0 splits epoch seconds. Mode 1 normalizes the month into the year,
//  clamps the year to 1970..2105, forms the epoch modulo 2^32 and then splits
//  it in the same stages as mode 0.
module epoch_calendar_converter_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // epoch_in[31:0], year_in[43:32], month_in[51:44], day_in[59:52],
    // hour_in[67:60], minute_in[75:68], second_in[83:76], zero fill above
    input  wire logic [ecc_pkg::InDataW-1:0]  s_tdata,
    // mode[0]
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // epoch_out[31:0], year_out[43:32], month_out[47:44], day_out[52:48],
    // weekday_out[55:53], leap_out[56], day_count[72:57], hour_out[77:73],
    // minute_out[83:78], second_out[89:84], zero fill above
    output logic [ecc_pkg::OutDataW-1:0]      m_tdata
);
    import ecc_pkg::*;

    logic [NStage-1:0] vld_reg;
    logic [NStage-1:0] en;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    st6_t s6_reg, s6_next;
    st7_t s7_reg, s7_next;
    st8_t s8_reg, s8_next;
    logic [OutDataW-1:0] out_reg, out_next;

    // A stage loads when it is empty or its successor loads this cycle.
    always_comb
    begin
        en[NStage-1] = !vld_reg[NStage-1] || m_tready;
        for (int k = NStage - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NStage-1];
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NStage; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: fold the month into the year (floor division of month - 1 by
    // twelve, offset by 132 so it stays positive) and clamp the year.
    logic signed [8:0]  m_ext;
    logic [8:0]         m_pos;
    logic [18:0]        m_prod;
    logic [4:0]         m_q;
    logic [8:0]         m_rem;
    logic signed [13:0] yr_raw;
    logic signed [13:0] yr_cl;

    always_comb
    begin
        m_ext = {s_tdata[51], s_tdata[51:44]};
        m_pos = 9'(m_ext + 9'sd131);
        m_prod = 19'(m_pos * 10'd683);
        m_q = m_prod[17:13];
        m_rem = m_pos - (9'(m_q) << 3) - (9'(m_q) << 2);
        yr_raw = $signed({2'b00, s_tdata[43:32]}) + $signed({9'b0, m_q}) - 14'sd11;
        if (yr_raw < 14'sd1970)
        begin
            yr_cl = 14'sd1970;
        end
        else if (yr_raw > 14'sd2105)
        begin
            yr_cl = 14'sd2105;
        end
        else
        begin
            yr_cl = yr_raw;
        end
        s1_next.mode = s_tuser;
        s1_next.epoch = s_tdata[31:0];
        s1_next.yoff = 8'(yr_cl - 14'sd1970);
        s1_next.midx = m_rem[3:0];
        s1_next.day = s_tdata[59:52];
        s1_next.hour = s_tdata[67:60];
        s1_next.minute = s_tdata[75:68];
        s1_next.second = s_tdata[83:76];
    end

    // Stage 2: day number of the date and seconds of the time fields.
    logic [8:0] b_moff;

    always_comb
    begin
        b_moff = month_base(s1_reg.midx);
        if (leap_of(s1_reg.yoff) && (s1_reg.midx > 4'd1))
        begin
            b_moff = b_moff + 9'd1;
        end
        s2_next.mode = s1_reg.mode;
        s2_next.epoch = s1_reg.epoch;
        s2_next.days = $signed({2'b00, days_before(s1_reg.yoff)})
                     + $signed({9'b0, b_moff}) + $signed({10'b0, s1_reg.day}) - 18'sd1;
        s2_next.tsec = 20'(s1_reg.hour * 12'd3600) + 20'(s1_reg.minute * 6'd60)
                     + 20'(s1_reg.second);
    end

    // Stage 3: epoch modulo 2^32, or the input epoch in mode 0.
    always_comb
    begin
        if (s2_reg.mode == MODE_BUILD)
        begin
            s3_next.epoch = 32'($signed(32'(s2_reg.days)) * $signed({1'b0, 17'd86400}))
                          + 32'(s2_reg.tsec);
        end
        else
        begin
            s3_next.epoch = s2_reg.epoch;
        end
    end

    // Stage 4: day count, epoch / 86400 as (epoch >> 7) / 675 by reciprocal.
    logic [50:0] d_prod;

    always_comb
    begin
        d_prod = 51'(s3_reg.epoch[31:7] * 26'd50903317);
        s4_next.epoch = s3_reg.epoch;
        s4_next.days = d_prod[50:35];
    end

    // Stage 5: seconds of the day and a first guess of the year.
    logic [31:0] y_prod;

    always_comb
    begin
        y_prod = 32'(s4_reg.days * 16'd45965);
        s5_next.epoch = s4_reg.epoch;
        s5_next.days = s4_reg.days;
        s5_next.tod = 17'(s4_reg.epoch - 32'(s4_reg.days * 17'd86400));
        s5_next.yq = y_prod[31:24];
    end

    // Stage 6: correct the year guess, day of the year, hour and weekday quotient.
    logic [15:0] y_hi;
    logic [15:0] y_lo;
    logic [7:0]  y_sel;
    logic [15:0] y_base;
    logic [25:0] h_prod;
    logic [35:0] w_prod;

    always_comb
    begin
        y_hi = days_before(s5_reg.yq);
        y_lo = days_before(s5_reg.yq - 8'd1);
        if (y_hi > s5_reg.days)
        begin
            y_sel = s5_reg.yq - 8'd1;
            y_base = y_lo;
        end
        else
        begin
            y_sel = s5_reg.yq;
            y_base = y_hi;
        end
        h_prod = 26'(s5_reg.tod[16:4] * 13'd4661);
        w_prod = 36'((17'(s5_reg.days) + 17'd4) * 19'd74899);
        s6_next.epoch = s5_reg.epoch;
        s6_next.days = s5_reg.days;
        s6_next.tod = s5_reg.tod;
        s6_next.yoff = y_sel;
        s6_next.sod = 9'(s5_reg.days - y_base);
        s6_next.leap = leap_of(y_sel);
        s6_next.hour = h_prod[24:20];
        s6_next.wq = w_prod[31:19];
    end

    // Stage 7: month search, weekday remainder and seconds within the hour.
    logic [8:0]  c_off;
    logic [8:0]  c_sel;
    logic [3:0]  c_mon;
    logic [16:0] c_w;

    always_comb
    begin
        c_sel = 9'd0;
        c_mon = 4'd1;
        for (int i = 0; i < 12; i++)
        begin
            c_off = month_base(4'(i));
            if (s6_reg.leap && (i > 1))
            begin
                c_off = c_off + 9'd1;
            end
            if (c_off <= s6_reg.sod)
            begin
                c_sel = c_off;
                c_mon = 4'(i + 1);
            end
        end
        c_off = 9'd0;
        c_w = 17'(s6_reg.days) + 17'd4;
        s7_next.epoch = s6_reg.epoch;
        s7_next.days = s6_reg.days;
        s7_next.yoff = s6_reg.yoff;
        s7_next.leap = s6_reg.leap;
        s7_next.month = c_mon;
        s7_next.day = 5'(s6_reg.sod - c_sel + 9'd1);
        s7_next.wday = 3'(c_w - 17'(s6_reg.wq * 4'd7));
        s7_next.hour = s6_reg.hour;
        s7_next.remh = 12'(s6_reg.tod - 17'(s6_reg.hour * 12'd3600));
    end

    // Stage 8: minute as (remh >> 2) / 15 by reciprocal.
    logic [20:0] n_prod;

    always_comb
    begin
        n_prod = 21'(s7_reg.remh[11:2] * 11'd1093);
        s8_next.epoch = s7_reg.epoch;
        s8_next.days = s7_reg.days;
        s8_next.yoff = s7_reg.yoff;
        s8_next.leap = s7_reg.leap;
        s8_next.month = s7_reg.month;
        s8_next.day = s7_reg.day;
        s8_next.wday = s7_reg.wday;
        s8_next.hour = s7_reg.hour;
        s8_next.minute = n_prod[19:14];
        s8_next.remh = s7_reg.remh;
    end

    // Stage 9: second and the packed result.
    logic [5:0]  f_sec;
    logic [11:0] f_year;

    always_comb
    begin
        f_sec = 6'(s8_reg.remh - 12'(s8_reg.minute * 6'd60));
        f_year = 12'(s8_reg.yoff) + 12'd1970;
        out_next = {6'b0, f_sec, s8_reg.minute, s8_reg.hour, s8_reg.days, s8_reg.leap,
                    s8_reg.wday, s8_reg.day, s8_reg.month, f_year, s8_reg.epoch};
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) s1_reg <= s1_next;
        if (en[1]) s2_reg <= s2_next;
        if (en[2]) s3_reg <= s3_next;
        if (en[3]) s4_reg <= s4_next;
        if (en[4]) s5_reg <= s5_next;
        if (en[5]) s6_reg <= s6_next;
        if (en[6]) s7_reg <= s7_next;
        if (en[7]) s8_reg <= s8_next;
        if (en[8]) out_reg <= out_next;
    end

    // An accepted request always lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    // The input side only stalls when the whole pipe is full up to the output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // Calendar fields stay in range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:44] >= 4'd1 && m_tdata[47:44] <= 4'd12 &&
                      m_tdata[52:48] >= 5'd1 && m_tdata[55:53] <= 3'd6 &&
                      m_tdata[77:73] <= 5'd23 && m_tdata[83:78] <= 6'd59 &&
                      m_tdata[89:84] <= 6'd59))
        else $error("converted field out of range");

    // A leap year is a multiple of four.
    a_leap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[56]) |-> (m_tdata[33:32] == 2'b00))
        else $error("leap flag on a year that is not a multiple of four");

endmodule
`default_nettype wire
